// ===== src/lecm_pkg.sv =====
package lecm_pkg;

   localparam int BUFFER_BYTES = 32;
   localparam int IDX_W        = $clog2(BUFFER_BYTES);
   localparam int LEN_MAX      = BUFFER_BYTES - 1;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // command texts in ASCII, first character in the top byte
   localparam int ON_LEN  = 11;
   localparam int OFF_LEN = 12;
   localparam logic [ON_LEN*8-1:0]  CMD_ON  = {8'h54, 8'h75, 8'h72, 8'h6E, 8'h5F, 8'h6F,
                                               8'h6E, 8'h5F, 8'h6C, 8'h65, 8'h64};
   localparam logic [OFF_LEN*8-1:0] CMD_OFF = {8'h54, 8'h75, 8'h72, 8'h6E, 8'h5F, 8'h6F,
                                               8'h66, 8'h66, 8'h5F, 8'h6C, 8'h65, 8'h64};

   typedef enum logic [1:0] {
      LED_NONE = 2'd0,
      LED_ON   = 2'd1,
      LED_OFF  = 2'd2
   } led_req_type;

   typedef struct packed {
      logic store;
      logic start;
      logic emit_byte;
      logic emit_cr;
      logic emit_lf;
   } lecm_cmd_type;

   typedef struct packed {
      logic is_cr;
      logic is_lf;
      logic full;
      logic echo_done;
      logic out_free;
   } lecm_status_type;

   function automatic logic [7:0] cmd_on_char(input logic [IDX_W-1:0] k);
      logic [7:0] c;
      c = '0;
      if (int'(k) < ON_LEN) begin
         c = CMD_ON[(ON_LEN - 1 - int'(k)) * 8 +: 8];
      end
      return c;
   endfunction

   function automatic logic [7:0] cmd_off_char(input logic [IDX_W-1:0] k);
      logic [7:0] c;
      c = '0;
      if (int'(k) < OFF_LEN) begin
         c = CMD_OFF[(OFF_LEN - 1 - int'(k)) * 8 +: 8];
      end
      return c;
   endfunction

endpackage

// ===== src/lecm_ram.sv =====
module lecm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lecm_dp.sv =====
module lecm_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_rx_byte,
   input  logic                      rsp_ready,
   input  lecm_pkg::lecm_cmd_type    cmd,
   output lecm_pkg::lecm_status_type status,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_last,
   output logic [1:0]                rsp_led_request
);
   import lecm_pkg::*;

   logic [IDX_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             match_on_ff, match_on_in;
   logic             match_off_ff, match_off_in;
   logic             valid_ff, valid_in;
   logic [7:0]       tx_ff, tx_in;
   logic             last_ff, last_in;
   led_req_type      led_ff, led_in;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic             on_hit, off_hit;
   led_req_type      led_end;

   lecm_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (len_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read address runs one ahead when a byte leaves, so data is ready every cycle
   assign rd_addr = cmd.emit_byte ? idx_ff + 1'b1 : idx_ff;

   assign on_hit  = (int'(idx_ff) < ON_LEN)  && (rd_data == cmd_on_char(idx_ff));
   assign off_hit = (int'(idx_ff) < OFF_LEN) && (rd_data == cmd_off_char(idx_ff));

   always_comb begin
      led_end = LED_NONE;
      if (match_on_ff && idx_ff == IDX_W'(ON_LEN)) begin
         led_end = LED_ON;
      end else if (match_off_ff && idx_ff == IDX_W'(OFF_LEN)) begin
         led_end = LED_OFF;
      end
   end

   assign status.is_cr     = (req_rx_byte == CH_CR);
   assign status.is_lf     = (req_rx_byte == CH_LF);
   assign status.full      = (len_ff == IDX_W'(LEN_MAX));
   assign status.echo_done = (idx_ff == len_ff) || (rd_data == 8'h00);
   assign status.out_free  = !valid_ff || rsp_ready;

   always_comb begin
      len_in       = len_ff;
      idx_in       = idx_ff;
      match_on_in  = match_on_ff;
      match_off_in = match_off_ff;
      valid_in     = valid_ff;
      tx_in        = tx_ff;
      last_in      = last_ff;
      led_in       = led_ff;

      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.store) begin
         len_in = len_ff + 1'b1;
      end
      if (cmd.start) begin
         idx_in       = '0;
         match_on_in  = 1'b1;
         match_off_in = 1'b1;
      end
      if (cmd.emit_byte) begin
         idx_in       = idx_ff + 1'b1;
         match_on_in  = match_on_ff && on_hit;
         match_off_in = match_off_ff && off_hit;
         valid_in     = 1'b1;
         tx_in        = rd_data;
         last_in      = 1'b0;
         led_in       = LED_NONE;
      end
      if (cmd.emit_cr) begin
         valid_in = 1'b1;
         tx_in    = CH_CR;
         last_in  = 1'b0;
         led_in   = LED_NONE;
      end
      if (cmd.emit_lf) begin
         valid_in = 1'b1;
         tx_in    = CH_LF;
         last_in  = 1'b1;
         led_in   = led_end;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
      idx_ff       <= idx_in;
      match_on_ff  <= match_on_in;
      match_off_ff <= match_off_in;
      tx_ff        <= tx_in;
      last_ff      <= last_in;
      led_ff       <= led_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_last        = last_ff;
   assign rsp_led_request = led_ff;

endmodule

// ===== src/lecm_ctrl.sv =====
module lecm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lecm_pkg::lecm_status_type status,
   output lecm_pkg::lecm_cmd_type    cmd
);
   import lecm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_ECHO,
      ST_SEND_CR,
      ST_SEND_LF
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && status.is_lf) begin
               cmd.start = 1'b1;
               state_in  = ST_PRIME;
            end else if (take && !status.is_cr && !status.full) begin
               cmd.store = 1'b1;
            end
         end
         ST_PRIME: begin
            state_in = ST_ECHO;
         end
         ST_ECHO: begin
            if (status.echo_done) begin
               state_in = ST_SEND_CR;
            end else if (status.out_free) begin
               cmd.emit_byte = 1'b1;
            end
         end
         ST_SEND_CR: begin
            if (status.out_free) begin
               cmd.emit_cr = 1'b1;
               state_in    = ST_SEND_LF;
            end
         end
         ST_SEND_LF: begin
            if (status.out_free) begin
               cmd.emit_lf = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/line_echo_command_matcher.sv =====
// channel | ports                                   | dir | handshake
// req     | req_rx_byte                             | in  | req_valid / req_ready
// rsp     | rsp_tx_byte, rsp_last, rsp_led_request  | out | rsp_valid / rsp_ready
//
// Ordinary bytes and CR are taken without leaving idle; a word is accepted whenever idle.
// After a line feed, req_ready stays low while the controller primes the line RAM
// read port, echoes the stored bytes one by one, sees the end of the line, then
// sends CR and LF.
// The line RAM read port streams one byte per cycle; rsp stalls hold the echo in place.
// Synchronous reset empties the line; line RAM contents are left as they are.
module line_echo_command_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic [1:0] rsp_led_request
);
   import lecm_pkg::*;

   lecm_cmd_type    cmd;
   lecm_status_type status;

   lecm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lecm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_led_request (rsp_led_request)
   );

`ifndef ASSERT_OFF
   a_last_is_lf : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_tx_byte == CH_LF)
      else $error("final word of echo is not a line feed");

   a_led_only_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_led_request != LED_NONE |-> rsp_last)
      else $error("LED request on a word other than the last");

   a_busy_after_lf : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_rx_byte == CH_LF |=> !req_ready)
      else $error("input accepted straight after a line feed");

   a_led_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_led_request != 2'd3)
      else $error("invalid LED request code");
`endif

endmodule
